@@ hdl/prescaled_up_down_timer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Prescaled up/down timer: assertion macros
// Shared assertion forms for the timer RTL; clocked on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef PRESCALED_UP_DOWN_TIMER_UNIT_DEFINES_SVH
`define PRESCALED_UP_DOWN_TIMER_UNIT_DEFINES_SVH

// Same-cycle implication
`define PUDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer assertion failed");

// Next-cycle implication
`define PUDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer assertion failed");

`endif

@@ hdl/pudt_pkg.sv @@
// ----------------------------------------------------------------------------
// Prescaled up/down timer package
// Item types, register map, opcodes and counter width.
// ----------------------------------------------------------------------------
package pudt_pkg;

  // Main counter width
  localparam int COUNT_WIDTH = 16;

  // Opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Register map
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd1;
  localparam logic [2:0] REG_EGR    = 3'd2;
  localparam logic [2:0] REG_CNT    = 3'd3;
  localparam logic [2:0] REG_PSC    = 3'd4;
  localparam logic [2:0] REG_ARR    = 3'd5;

  // Control register bit positions
  localparam int CTRL_EN_BIT   = 0;
  localparam int CTRL_UDIS_BIT = 1;
  localparam int CTRL_OPM_BIT  = 3;
  localparam int CTRL_DIR_BIT  = 4;
  localparam int CTRL_ARPE_BIT = 7;

  // Status and event generate bit
  localparam int UIF_BIT = 0;
  localparam int UG_BIT  = 0;

  typedef struct packed {
    logic        arpe;
    logic        dir;
    logic        opm;
    logic        udis;
    logic        en;
  } ctrl_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  reg_index;
    logic [15:0] write_value;
  } pudt_in_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic        update_flag;
    logic        running;
  } pudt_out_t;

endpackage

@@ hdl/pudt_core.sv @@
// ----------------------------------------------------------------------------
// Prescaled up/down timer core
// Holds the timer state and works out one item per cycle: tick, register
// write or register read. Its result is combinational from state and item.
// ----------------------------------------------------------------------------
`include "prescaled_up_down_timer_unit_defines.svh"

module pudt_core
  import pudt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  pudt_in_t  item,
  output pudt_out_t result
);

  // State
  ctrl_t                  ctrl, ctrl_next;
  logic                   flag, flag_next;
  logic [15:0]            psc_set, psc_set_next;
  logic [15:0]            psc_act, psc_act_next;
  logic [15:0]            psc_cnt, psc_cnt_next;
  logic [COUNT_WIDTH-1:0] arr_set, arr_set_next;
  logic [COUNT_WIDTH-1:0] arr_act, arr_act_next;
  logic [COUNT_WIDTH-1:0] count, count_next;

  logic                   step;
  logic                   wrap;
  logic                   gen;
  logic                   upd;
  logic [15:0]            rd;

  // Item decode and next state
  always_comb begin
    ctrl_next    = ctrl;
    flag_next    = flag;
    psc_set_next = psc_set;
    psc_act_next = psc_act;
    psc_cnt_next = psc_cnt;
    arr_set_next = arr_set;
    arr_act_next = arr_act;
    count_next   = count;
    step         = 1'b0;
    wrap         = 1'b0;
    gen          = 1'b0;
    upd          = 1'b0;
    rd           = '0;

    if (fire) begin
      case (item.opcode)
        OP_TICK: begin
          if (ctrl.en) begin
            if (psc_cnt >= psc_act) begin
              psc_cnt_next = '0;
              step         = 1'b1;
            end else begin
              psc_cnt_next = psc_cnt + 16'd1;
            end
          end
        end
        OP_WRITE: begin
          case (item.reg_index)
            REG_CTRL: begin
              ctrl_next.en   = item.write_value[CTRL_EN_BIT];
              ctrl_next.udis = item.write_value[CTRL_UDIS_BIT];
              ctrl_next.opm  = item.write_value[CTRL_OPM_BIT];
              ctrl_next.dir  = item.write_value[CTRL_DIR_BIT];
              ctrl_next.arpe = item.write_value[CTRL_ARPE_BIT];
            end
            REG_STATUS: begin
              if (!item.write_value[UIF_BIT]) flag_next = 1'b0;
            end
            REG_EGR: begin
              gen = item.write_value[UG_BIT];
            end
            REG_CNT: begin
              count_next = COUNT_WIDTH'(item.write_value);
            end
            REG_PSC: begin
              psc_set_next = item.write_value;
            end
            REG_ARR: begin
              arr_set_next = COUNT_WIDTH'(item.write_value);
              if (!ctrl.arpe) arr_act_next = COUNT_WIDTH'(item.write_value);
            end
            default: ;
          endcase
        end
        OP_READ: begin
          case (item.reg_index)
            REG_CTRL: begin
              rd[CTRL_EN_BIT]   = ctrl.en;
              rd[CTRL_UDIS_BIT] = ctrl.udis;
              rd[CTRL_OPM_BIT]  = ctrl.opm;
              rd[CTRL_DIR_BIT]  = ctrl.dir;
              rd[CTRL_ARPE_BIT] = ctrl.arpe;
            end
            REG_STATUS: rd[UIF_BIT] = flag;
            REG_CNT:    rd = 16'(count);
            REG_PSC:    rd = psc_set;
            REG_ARR:    rd = 16'(arr_set);
            default:    rd = '0;
          endcase
        end
        default: ;
      endcase
    end

    // Counter step on prescaler wrap
    if (step) begin
      if (ctrl.dir) begin
        if (count == '0) wrap = 1'b1;
        else count_next = count - COUNT_WIDTH'(1);
      end else begin
        if (count == arr_act) wrap = 1'b1;
        else count_next = count + COUNT_WIDTH'(1);
      end
    end

    // Update event: overflow, underflow or software generate
    upd = (wrap || gen) && !ctrl.udis;
    if (upd) begin
      psc_act_next = psc_set;
      arr_act_next = arr_set;
      flag_next    = 1'b1;
      if (ctrl.opm) ctrl_next.en = 1'b0;
    end

    // Counter reinitialise
    if (wrap || gen) count_next = ctrl.dir ? arr_act_next : '0;
    if (gen) psc_cnt_next = '0;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl    <= '0;
      flag    <= 1'b0;
      psc_set <= '0;
      psc_act <= '0;
      psc_cnt <= '0;
      arr_set <= '1;
      arr_act <= '1;
      count   <= '0;
    end else begin
      ctrl    <= ctrl_next;
      flag    <= flag_next;
      psc_set <= psc_set_next;
      psc_act <= psc_act_next;
      psc_cnt <= psc_cnt_next;
      arr_set <= arr_set_next;
      arr_act <= arr_act_next;
      count   <= count_next;
    end
  end

  assign result.read_value  = rd;
  assign result.update_flag = flag_next;
  assign result.running     = ctrl_next.en;

  // Assertions
  `PUDT_ASSERT_NEXT(a_idle_holds, !fire,
    $stable(count) && $stable(flag) && $stable(ctrl) && $stable(psc_cnt))
  `PUDT_ASSERT_NEXT(a_tick_disabled, fire && item.opcode == OP_TICK && !ctrl.en,
    $stable(count) && $stable(psc_cnt) && $stable(flag))
  `PUDT_ASSERT_NEXT(a_prescale_inc,
    fire && item.opcode == OP_TICK && ctrl.en && psc_cnt < psc_act,
    psc_cnt == $past(psc_cnt) + 16'd1 && $stable(count))
  `PUDT_ASSERT_NEXT(a_ug_sets_flag,
    fire && item.opcode == OP_WRITE && item.reg_index == REG_EGR &&
    item.write_value[UG_BIT] && !ctrl.udis,
    flag && psc_cnt == '0)

endmodule

@@ hdl/prescaled_up_down_timer_unit.sv @@
// ----------------------------------------------------------------------------
// Prescaled up/down timer unit
// 16-bit general purpose timer with prescaler, reload shadow and update
// flag, driven by an item stream of ticks, register writes and reads.
//
//   channel | direction | handshake            | payload
//   cmd     | in        | cmd_valid/cmd_stall  | pudt_in_t  (opcode, index, data)
//   rsp     | out       | rsp_valid/rsp_stall  | pudt_out_t (read, flag, running)
//
// One item per cycle sustained while rsp is not stalled; an accepted item waits
// in the input register, and the result register captures its result on the
// edge at which the item fires, the state updating on that same edge.
// Synchronous reset clears control and timer state; reloads go to all ones.
// A stalled result holds in the result register; the input register still
// takes one more item, after which cmd_stall rises until rsp drains.
// ----------------------------------------------------------------------------
module prescaled_up_down_timer_unit
  import pudt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  pudt_in_t  cmd,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output pudt_out_t rsp
);

  logic      s1_valid;
  pudt_in_t  s1_item;
  logic      rsp_free;
  logic      fire;
  pudt_out_t core_result;

  // Stage handshake
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign fire      = s1_valid && rsp_free;
  assign cmd_stall = s1_valid && !rsp_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      s1_item <= cmd;
    end
  end

  // Timer state and item processing
  pudt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_item),
    .result (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= core_result;
    end
  end

endmodule
